// ===== design/lca_pkg.sv =====
package lca_pkg;

    localparam int unsigned NODE_W        = 10;
    localparam int unsigned CMD_W         = 2;
    localparam int unsigned NODES_DEF     = 1024;
    localparam int unsigned TOP_LEVEL_DEF = 9;
    localparam int unsigned MOD_SHIFT     = 2 * NODE_W;
    localparam int unsigned PROD_W        = 32;

    localparam logic [CMD_W-1:0] CMD_ROOT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ATTACH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

    typedef enum logic [1:0] {
        MOD_NONE,
        MOD_RECIP,
        MOD_SCALE,
        MOD_REDUCE
    } t_mod_op;

    typedef enum logic [2:0] {
        LVL_HOLD,
        LVL_CLR,
        LVL_INC,
        LVL_DEC,
        LVL_TOP
    } t_lvl_op;

    typedef enum logic [2:0] {
        UV_HOLD,
        UV_V_TO_U,
        UV_QA_TO_U,
        UV_ORDER,
        UV_LIFT,
        UV_CLIMB
    } t_uv_op;

    typedef enum logic [1:0] {
        AW_A,
        AW_V,
        AW_QA
    } t_awsel;

    typedef enum logic {
        DW_ZERO,
        DW_INC
    } t_dwsel;

    typedef enum logic {
        OS_U,
        OS_QA
    } t_osel;

    typedef struct packed {
        logic    in_ready;
        t_mod_op mod_op;
        t_lvl_op lvl_op;
        t_uv_op  uv_op;
        logic    anc_we;
        t_awsel  anc_wsel;
        logic    dep_we;
        t_dwsel  dep_wsel;
        logic    out_load;
        t_osel   out_sel;
    } t_ctrl;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             lvl_top;
        logic             lvl_zero;
        logic             diff_zero;
        logic             rest_zero;
        logic             uv_eq;
        logic             out_free;
    } t_stat;

    localparam t_ctrl CTRL_NOP = '{
        in_ready: 1'b0,
        mod_op:   MOD_NONE,
        lvl_op:   LVL_HOLD,
        uv_op:    UV_HOLD,
        anc_we:   1'b0,
        anc_wsel: AW_A,
        dep_we:   1'b0,
        dep_wsel: DW_ZERO,
        out_load: 1'b0,
        out_sel:  OS_U
    };

endpackage

// ===== design/lca_useq.sv =====
module lca_useq import lca_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_stat i_stat,
    output t_ctrl o_ctrl
);

    typedef enum logic [4:0] {
        S_IDLE, S_M1, S_M2, S_M3,
        S_RT,
        S_AT0, S_AT1, S_ATR, S_ATW,
        S_Q0, S_Q1, S_LR, S_LD, S_CHK, S_OU, S_CR, S_CD, S_FR, S_FD
    } t_step;

    typedef enum logic [3:0] {
        C_ALWAYS,
        C_IN_VALID,
        C_DISPATCH,
        C_LVL_TOP,
        C_LVL_ZERO,
        C_DIFF_ZERO,
        C_REST_ZERO,
        C_UV_EQ,
        C_OUT_FREE
    } t_cond;

    typedef struct packed {
        t_cond cond;
        t_step tgt_t;
        t_step tgt_f;
        t_ctrl ctrl;
    } t_uword;

    function automatic t_uword urom(input t_step s);
        t_uword w;
        w.cond  = C_ALWAYS;
        w.tgt_t = S_IDLE;
        w.tgt_f = S_IDLE;
        w.ctrl  = CTRL_NOP;
        case (s)
            S_IDLE: begin
                w.ctrl.in_ready = 1'b1;
                w.cond = C_IN_VALID; w.tgt_t = S_M1; w.tgt_f = S_IDLE;
            end
            S_M1: begin
                w.ctrl.mod_op = MOD_RECIP;
                w.tgt_t = S_M2;
            end
            S_M2: begin
                w.ctrl.mod_op = MOD_SCALE;
                w.tgt_t = S_M3;
            end
            S_M3: begin
                w.ctrl.mod_op = MOD_REDUCE;
                w.ctrl.lvl_op = LVL_CLR;
                w.cond = C_DISPATCH;
            end
            S_RT: begin
                w.ctrl.anc_we   = 1'b1;
                w.ctrl.anc_wsel = AW_A;
                w.ctrl.dep_we   = 1'b1;
                w.ctrl.dep_wsel = DW_ZERO;
                w.ctrl.lvl_op   = LVL_INC;
                w.cond = C_LVL_TOP; w.tgt_t = S_IDLE; w.tgt_f = S_RT;
            end
            S_AT0: begin
                w.ctrl.anc_we   = 1'b1;
                w.ctrl.anc_wsel = AW_V;
                w.ctrl.uv_op    = UV_V_TO_U;
                w.tgt_t = S_AT1;
            end
            S_AT1: begin
                w.ctrl.dep_we   = 1'b1;
                w.ctrl.dep_wsel = DW_INC;
                w.ctrl.lvl_op   = LVL_INC;
                w.tgt_t = S_ATW;
            end
            S_ATR: begin
                w.ctrl.lvl_op = LVL_INC;
                w.tgt_t = S_ATW;
            end
            S_ATW: begin
                w.ctrl.anc_we   = 1'b1;
                w.ctrl.anc_wsel = AW_QA;
                w.ctrl.uv_op    = UV_QA_TO_U;
                w.cond = C_LVL_TOP; w.tgt_t = S_IDLE; w.tgt_f = S_ATR;
            end
            S_Q0: begin
                w.tgt_t = S_Q1;
            end
            S_Q1: begin
                w.ctrl.uv_op = UV_ORDER;
                w.cond = C_DIFF_ZERO; w.tgt_t = S_CHK; w.tgt_f = S_LR;
            end
            S_LR: begin
                w.tgt_t = S_LD;
            end
            S_LD: begin
                w.ctrl.uv_op  = UV_LIFT;
                w.ctrl.lvl_op = LVL_INC;
                w.cond = C_REST_ZERO; w.tgt_t = S_CHK; w.tgt_f = S_LR;
            end
            S_CHK: begin
                w.ctrl.lvl_op = LVL_TOP;
                w.cond = C_UV_EQ; w.tgt_t = S_OU; w.tgt_f = S_CR;
            end
            S_OU: begin
                w.ctrl.out_load = 1'b1;
                w.ctrl.out_sel  = OS_U;
                w.cond = C_OUT_FREE; w.tgt_t = S_IDLE; w.tgt_f = S_OU;
            end
            S_CR: begin
                w.tgt_t = S_CD;
            end
            S_CD: begin
                w.ctrl.uv_op  = UV_CLIMB;
                w.ctrl.lvl_op = LVL_DEC;
                w.cond = C_LVL_ZERO; w.tgt_t = S_FR; w.tgt_f = S_CR;
            end
            S_FR: begin
                w.tgt_t = S_FD;
            end
            S_FD: begin
                w.ctrl.out_load = 1'b1;
                w.ctrl.out_sel  = OS_QA;
                w.cond = C_OUT_FREE; w.tgt_t = S_IDLE; w.tgt_f = S_FD;
            end
            default: begin
                w.tgt_t = S_IDLE;
            end
        endcase
        return w;
    endfunction

    t_step  r_step;
    t_step  n_step;
    t_uword word;
    logic   take;

    assign word   = urom(r_step);
    assign o_ctrl = word.ctrl;

    always_comb begin
        case (word.cond)
            C_ALWAYS:    take = 1'b1;
            C_IN_VALID:  take = i_in_valid;
            C_LVL_TOP:   take = i_stat.lvl_top;
            C_LVL_ZERO:  take = i_stat.lvl_zero;
            C_DIFF_ZERO: take = i_stat.diff_zero;
            C_REST_ZERO: take = i_stat.rest_zero;
            C_UV_EQ:     take = i_stat.uv_eq;
            C_OUT_FREE:  take = i_stat.out_free;
            default:     take = 1'b1;
        endcase
    end

    always_comb begin
        if (word.cond == C_DISPATCH) begin
            case (i_stat.cmd)
                CMD_ROOT:   n_step = S_RT;
                CMD_ATTACH: n_step = S_AT0;
                CMD_QUERY:  n_step = S_Q0;
                default:    n_step = S_IDLE;
            endcase
        end else begin
            n_step = take ? word.tgt_t : word.tgt_f;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

// ===== design/lca_dpath.sv =====
module lca_dpath import lca_pkg::*; #(
    parameter int unsigned NODES     = NODES_DEF,
    parameter int unsigned TOP_LEVEL = TOP_LEVEL_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ctrl             i_ctrl,
    output t_stat             o_stat,
    input  logic              i_accept,
    input  logic [CMD_W-1:0]  i_cmd,
    input  logic [NODE_W-1:0] i_node_a,
    input  logic [NODE_W-1:0] i_node_b,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output logic [NODE_W-1:0] o_ancestor
);

    localparam int unsigned LEVELS    = TOP_LEVEL + 1;
    localparam int unsigned NW        = $clog2(NODES);
    localparam int unsigned LW        = $clog2(LEVELS);
    localparam int unsigned AW        = NW + LW;
    localparam int unsigned ANC_DEPTH = 2 ** AW;
    localparam int unsigned DIFF_W    = (NW > LEVELS) ? NW : LEVELS;
    localparam int unsigned RECIP     = (2 ** MOD_SHIFT) / NODES;

    localparam logic [PROD_W-1:0] RECIP_W  = PROD_W'(RECIP);
    localparam logic [PROD_W-1:0] NODES_W  = PROD_W'(NODES);
    localparam logic [NW-1:0]     DEP_MAX  = NW'(NODES - 1);
    localparam logic [LW-1:0]     LVL_LAST = LW'(TOP_LEVEL);

    logic [NW-1:0] anc_mem [ANC_DEPTH];
    logic [NW-1:0] dep_mem [NODES];

    logic [CMD_W-1:0]  r_cmd;
    logic [NODE_W-1:0] r_ra, r_rb;
    logic [PROD_W-1:0] r_pa, r_pb;
    logic [NW-1:0]     r_a, r_u, r_v;
    logic [LW-1:0]     r_lvl;
    logic [LEVELS-1:0] r_diff;
    logic [NW-1:0]     r_qa, r_qb;
    logic [NW-1:0]     r_da, r_db;
    logic              r_out_valid;
    logic [NODE_W-1:0] r_ancestor;

    logic [PROD_W-1:0] rem_a, rem_b, red_a, red_b;
    logic [DIFF_W-1:0] d_ab, d_ba;
    logic              d_lt;
    logic [LEVELS-1:0] new_diff;
    logic [NW-1:0]     anc_wdata, dep_wdata;
    logic              out_free;

    // remainder after reciprocal estimate lies below twice NODES
    assign rem_a = PROD_W'(r_ra) - r_pa;
    assign rem_b = PROD_W'(r_rb) - r_pb;
    assign red_a = (rem_a >= NODES_W) ? rem_a - NODES_W : rem_a;
    assign red_b = (rem_b >= NODES_W) ? rem_b - NODES_W : rem_b;

    assign d_lt     = r_da < r_db;
    assign d_ab     = DIFF_W'(r_da) - DIFF_W'(r_db);
    assign d_ba     = DIFF_W'(r_db) - DIFF_W'(r_da);
    assign new_diff = LEVELS'(d_lt ? d_ba : d_ab);

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        case (i_ctrl.anc_wsel)
            AW_A:    anc_wdata = r_a;
            AW_V:    anc_wdata = r_v;
            AW_QA:   anc_wdata = r_qa;
            default: anc_wdata = r_a;
        endcase
    end

    assign dep_wdata = (i_ctrl.dep_wsel == DW_ZERO) ? '0 :
                       (r_db >= DEP_MAX) ? DEP_MAX : r_db + NW'(1);

    assign o_stat.cmd       = r_cmd;
    assign o_stat.lvl_top   = r_lvl == LVL_LAST;
    assign o_stat.lvl_zero  = r_lvl == '0;
    assign o_stat.diff_zero = new_diff == '0;
    assign o_stat.rest_zero = r_diff[LEVELS-1:1] == '0;
    assign o_stat.uv_eq     = r_u == r_v;
    assign o_stat.out_free  = out_free;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.anc_we) begin
            anc_mem[{r_a, r_lvl}] <= anc_wdata;
        end
        if (i_ctrl.dep_we) begin
            dep_mem[r_a] <= dep_wdata;
        end
        r_qa <= anc_mem[{r_u, r_lvl}];
        r_qb <= anc_mem[{r_v, r_lvl}];
        r_da <= dep_mem[r_u];
        r_db <= dep_mem[r_v];
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_cmd <= i_cmd;
            r_ra  <= i_node_a;
            r_rb  <= i_node_b;
        end

        case (i_ctrl.mod_op)
            MOD_RECIP: begin
                r_pa <= PROD_W'(r_ra) * RECIP_W;
                r_pb <= PROD_W'(r_rb) * RECIP_W;
            end
            MOD_SCALE: begin
                r_pa <= (r_pa >> MOD_SHIFT) * NODES_W;
                r_pb <= (r_pb >> MOD_SHIFT) * NODES_W;
            end
            MOD_REDUCE: begin
                r_a <= NW'(red_a);
            end
            default: begin
            end
        endcase

        case (i_ctrl.lvl_op)
            LVL_CLR: r_lvl <= '0;
            LVL_INC: r_lvl <= r_lvl + LW'(1);
            LVL_DEC: r_lvl <= (r_lvl == '0) ? '0 : r_lvl - LW'(1);
            LVL_TOP: r_lvl <= LVL_LAST;
            default: r_lvl <= r_lvl;
        endcase

        if (i_ctrl.mod_op == MOD_REDUCE) begin
            r_u <= NW'(red_a);
            r_v <= NW'(red_b);
        end else begin
            case (i_ctrl.uv_op)
                UV_V_TO_U: begin
                    r_u <= r_v;
                end
                UV_QA_TO_U: begin
                    r_u <= r_qa;
                end
                UV_ORDER: begin
                    if (d_lt) begin
                        r_u <= r_v;
                        r_v <= r_u;
                    end
                    r_diff <= new_diff;
                end
                UV_LIFT: begin
                    if (r_diff[0]) begin
                        r_u <= r_qa;
                    end
                    r_diff <= r_diff >> 1;
                end
                UV_CLIMB: begin
                    if (r_qa != r_qb) begin
                        r_u <= r_qa;
                        r_v <= r_qb;
                    end
                end
                default: begin
                end
            endcase
        end

        if (i_ctrl.out_load && out_free) begin
            r_ancestor <= NODE_W'((i_ctrl.out_sel == OS_QA) ? r_qa : r_u);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.out_load && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_ancestor  = r_ancestor;

endmodule

// ===== design/lowest_common_ancestor_engine.sv =====
// Lowest common ancestor engine, binary lifting over a stored ancestor table.
// Input channel (i_in_valid / o_in_stall) takes one command word: root, attach
// node_a under node_b, or query node_a and node_b. A word is taken when valid
// is high and stall is low; stall is low only while the sequencer is idle.
// Output channel (o_out_valid / i_out_stall) returns one word per query; root
// and attach return nothing. The output register holds a stalled word, and
// the next command is accepted while it waits.
// Timing: one step of the microcode program per cycle. Root writes every
//   level of the table, attach does one dependent table read and write
//   per level, and query runs lift over the bits of the depth difference
//   and then climb unless the nodes already match, lift and climb each
//   taking a memory read and an update per level.
// Node numbers are reduced modulo NODES in three steps before dispatch.
// Reset returns the sequencer to idle and drops o_out_valid; table contents
// are not cleared and read as garbage until written.
module lowest_common_ancestor_engine import lca_pkg::*; #(
    parameter int unsigned NODES     = NODES_DEF,
    parameter int unsigned TOP_LEVEL = TOP_LEVEL_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [CMD_W-1:0]  i_cmd,
    input  logic [NODE_W-1:0] i_node_a,
    input  logic [NODE_W-1:0] i_node_b,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [NODE_W-1:0] o_ancestor
);

    t_ctrl ctrl;
    t_stat stat;
    logic  accept;

    assign accept     = i_in_valid && ctrl.in_ready;
    assign o_in_stall = !ctrl.in_ready;

    lca_useq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_ctrl     (ctrl)
    );

    lca_dpath #(
        .NODES     (NODES),
        .TOP_LEVEL (TOP_LEVEL)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .o_stat      (stat),
        .i_accept    (accept),
        .i_cmd       (i_cmd),
        .i_node_a    (i_node_a),
        .i_node_b    (i_node_b),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_ancestor  (o_ancestor)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accepted word");

    a_valid_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(ctrl.out_load))
        else $error("output valid without result step");

    a_wait_on_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctrl.out_load && !stat.out_free) |=> (o_in_stall && o_out_valid))
        else $error("result step left while output register full");

    a_load_only_idle_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.out_load |-> !ctrl.in_ready)
        else $error("result step overlaps idle");

endmodule
